// ----- hw/rtl/ffca_pkg.sv -----
// ffca_pkg: shared codes and control/status types for the first-fit allocator.
// No dependencies; imported by the top level, ffca_ctrl, ffca_dp and the testbench.
package ffca_pkg;

  typedef enum logic [2:0] {
    OP_REQUEST  = 3'd0,
    OP_RELEASE  = 3'd1,
    OP_FIND     = 3'd2,
    OP_LIST_FREE = 3'd3,
    OP_LIST_USED = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    K_ALLOC    = 4'd0,
    K_REQFAIL  = 4'd1,
    K_FREED    = 4'd2,
    K_RELFAIL  = 4'd3,
    K_FOUND    = 4'd4,
    K_FAULT    = 4'd5,
    K_HOLE     = 4'd6,
    K_ASSIGNED = 4'd7,
    K_NONE     = 4'd8
  } kind_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch command fields, clear scan state
    logic advance;  // step the scan one unit
    logic finish;   // emit the closing beat of the command
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;      // command completed inside the scan
    logic done;     // scan reached the end with nothing in flight
  } stat_t;

endpackage

// ----- hw/rtl/first_fit_contiguous_allocator.sv -----
// first_fit_contiguous_allocator: top level of the first-fit run allocator.
// Depends on ffca_pkg, ffca_ctrl, ffca_dp (and ffca_ram through ffca_dp).
//
// Usage:
//  - Command channel: a command beat is taken on a clock edge with start high
//    and busy low. Codes: request, release, find, list free holes, list
//    assigned entries. Codes 5..7 are taken and dropped with no result.
//  - Result channel: each result beat is shown for one cycle with strobe
//    high; the receiver cannot stall it. last marks the final beat of a
//    command. Lists give one beat per hole or entry, or a single none beat.
//  - Config channel: cfg_valid/cfg_ready (ready always high) writes
//    units_in_use; write it only while the block is idle.
//  - Timing: one bitmap unit / table entry is scanned per cycle, behind a
//    registered table read. Requests, releases and finds stop at the
//    first hit. The final result beat follows the hit or scan end in the
//    next cycle. A new command is taken only once busy has dropped.
//  - Reset (rst, synchronous): all units free, no entries, units_in_use 64.
//    No clearing pass; the table contents are only read behind valid bits.
module first_fit_contiguous_allocator #(
  parameter int NUM_UNITS  = 64,
  parameter int OWNER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [15:0] owner_id,
  input  logic [6:0]  request_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  units_in_use,
  output logic        strobe,
  output logic [3:0]  kind,
  output logic [15:0] owner,
  output logic [6:0]  size,
  output logic [5:0]  address,
  output logic        last
);
  import ffca_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  // config writes always land; the contract keeps them to idle periods
  assign cfg_ready = 1'b1;

  ffca_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .ctl     (ctl),
    .busy    (busy)
  );

  ffca_dp #(.NUM_UNITS(NUM_UNITS), .OWNER_BITS(OWNER_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .command      (command),
    .owner_id     (owner_id),
    .request_size (request_size),
    .cfg_valid    (cfg_valid),
    .units_in_use (units_in_use),
    .strobe       (strobe),
    .kind         (kind),
    .owner        (owner),
    .size         (size),
    .address      (address),
    .last         (last)
  );

endmodule

// ----- hw/rtl/ffca_ram.sv -----
// ffca_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module ffca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/ffca_ctrl.sv -----
// ffca_ctrl: command sequencer for the first-fit allocator.
// Depends on ffca_pkg.
module ffca_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2:0]     command,
  input  ffca_pkg::stat_t stat,
  output ffca_pkg::ctl_t  ctl,
  output logic           busy
);
  import ffca_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t state, state_next;
  logic   cmd_ok;

  assign cmd_ok = (command <= 3'(OP_LIST_USED));
  assign busy   = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    ctl         = '0;
    unique case (state)
      S_IDLE: begin
        if (start && cmd_ok) begin
          ctl.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.advance = 1'b1;
        if (stat.hit) begin
          state_next = S_IDLE;
        end else if (stat.done) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/ffca_dp.sv -----
// ffca_dp: bitmap, entry table and scan datapath of the first-fit allocator.
// Depends on ffca_pkg and ffca_ram.
module ffca_dp #(
  parameter int NUM_UNITS  = 64,
  parameter int OWNER_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  ffca_pkg::ctl_t  ctl,
  output ffca_pkg::stat_t stat,
  input  logic [2:0]      command,
  input  logic [15:0]     owner_id,
  input  logic [6:0]      request_size,
  input  logic            cfg_valid,
  input  logic [6:0]      units_in_use,
  output logic            strobe,
  output logic [3:0]      kind,
  output logic [15:0]     owner,
  output logic [6:0]      size,
  output logic [5:0]      address,
  output logic            last
);
  import ffca_pkg::*;

  localparam int IW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  localparam int CW = $clog2(NUM_UNITS + 1);
  localparam int RW = OWNER_BITS + 7;

  // config
  logic [6:0] cfg_units;
  logic [CW-1:0] n_units;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_units <= 7'd64;
    end else if (cfg_valid) begin
      cfg_units <= units_in_use;
    end
  end

  always_comb begin
    if (cfg_units == 7'd0) begin
      n_units = CW'(1);
    end else if (cfg_units > 7'(NUM_UNITS)) begin
      n_units = CW'(NUM_UNITS);
    end else begin
      n_units = CW'(cfg_units);
    end
  end

  // state
  logic [NUM_UNITS-1:0] used, used_next;
  logic [NUM_UNITS-1:0] valid, valid_next;
  op_t                  op, op_next;
  logic [OWNER_BITS-1:0] who, who_next;
  logic [6:0]           want, want_next;
  logic [CW-1:0]        cnt, cnt_next;
  logic                 d_valid, d_valid_next;
  logic [IW-1:0]        idx_d, idx_d_next;
  logic [6:0]           run, run_next;
  logic                 pend_valid, pend_valid_next;
  logic [OWNER_BITS-1:0] pend_owner, pend_owner_next;
  logic [6:0]           pend_size, pend_size_next;
  logic [IW-1:0]        pend_addr, pend_addr_next;

  logic                 strobe_next, last_next;
  logic [3:0]           kind_next;
  logic [15:0]          owner_next;
  logic [6:0]           size_next;
  logic [5:0]           address_next;

  // entry table
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [RW-1:0]        ram_wdata, ram_rdata;
  logic [OWNER_BITS-1:0] ram_owner;
  logic [6:0]           ram_len;

  assign ram_owner = ram_rdata[RW-1:7];
  assign ram_len   = ram_rdata[6:0];

  ffca_ram #(.WIDTH(RW), .DEPTH(NUM_UNITS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[IW-1:0]),
    .rdata (ram_rdata)
  );

  // unit range mask: s <= j < s + len
  function automatic logic [NUM_UNITS-1:0] range_mask(input logic [IW-1:0] s,
                                                      input logic [6:0] len);
    logic [7:0] hi;
    logic [NUM_UNITS-1:0] m;
    hi = 8'(s) + 8'(len);
    for (int j = 0; j < NUM_UNITS; j++) begin
      m[j] = (8'(j) >= 8'(s)) && (8'(j) < hi);
    end
    return m;
  endfunction

  logic [NUM_UNITS:0] used_ext;
  logic               used_i, end_i, hit, new_item;
  logic [IW-1:0]      req_start;
  logic [OWNER_BITS-1:0] item_owner;
  logic [6:0]         item_size;
  logic [IW-1:0]      item_addr;
  kind_t              list_kind;

  assign used_ext  = {1'b1, used};
  assign used_i    = used[idx_d];
  assign end_i     = (CW'(idx_d) + CW'(1) == n_units) || used_ext[CW'(idx_d) + CW'(1)];
  assign req_start = idx_d - IW'(run);
  assign list_kind = (op == OP_LIST_FREE) ? K_HOLE : K_ASSIGNED;

  always_comb begin
    used_next       = used;
    valid_next      = valid;
    op_next         = op;
    who_next        = who;
    want_next       = want;
    cnt_next        = cnt;
    d_valid_next    = 1'b0;
    idx_d_next      = idx_d;
    run_next        = run;
    pend_valid_next = pend_valid;
    pend_owner_next = pend_owner;
    pend_size_next  = pend_size;
    pend_addr_next  = pend_addr;
    strobe_next     = 1'b0;
    kind_next       = kind;
    owner_next      = owner;
    size_next       = size;
    address_next    = address;
    last_next       = last;
    ram_we          = 1'b0;
    ram_waddr       = req_start;
    ram_wdata       = {who, want};
    hit             = 1'b0;
    new_item        = 1'b0;
    item_owner      = '0;
    item_size       = '0;
    item_addr       = idx_d;

    // per-unit work on the delayed beat (table data now valid)
    if (d_valid) begin
      unique case (op)
        OP_REQUEST: begin
          if (used_i) begin
            run_next = '0;
          end else begin
            run_next = run + 7'd1;
            if (run + 7'd1 == want) begin
              hit = 1'b1;
              used_next = used | range_mask(req_start, want);
              valid_next[req_start] = 1'b1;
              ram_we       = 1'b1;
              strobe_next  = 1'b1;
              kind_next    = K_ALLOC;
              owner_next   = 16'(who);
              size_next    = want;
              address_next = 6'(req_start);
              last_next    = 1'b1;
            end
          end
        end
        OP_RELEASE, OP_FIND: begin
          if (valid[idx_d] && ram_owner == who) begin
            hit          = 1'b1;
            strobe_next  = 1'b1;
            kind_next    = (op == OP_RELEASE) ? K_FREED : K_FOUND;
            owner_next   = 16'(who);
            size_next    = ram_len;
            address_next = 6'(idx_d);
            last_next    = 1'b1;
            if (op == OP_RELEASE) begin
              used_next = used & ~range_mask(idx_d, ram_len);
              valid_next[idx_d] = 1'b0;
            end
          end
        end
        OP_LIST_FREE: begin
          if (used_i) begin
            run_next = '0;
          end else if (end_i) begin
            new_item  = 1'b1;
            item_size = run + 7'd1;
            item_addr = req_start;
            run_next  = '0;
          end else begin
            run_next = run + 7'd1;
          end
        end
        OP_LIST_USED: begin
          if (valid[idx_d]) begin
            new_item   = 1'b1;
            item_owner = ram_owner;
            item_size  = ram_len;
          end
        end
        default: ;
      endcase
    end

    // list beats go out one behind so the final one can carry last
    if (new_item) begin
      if (pend_valid) begin
        strobe_next  = 1'b1;
        kind_next    = list_kind;
        owner_next   = 16'(pend_owner);
        size_next    = pend_size;
        address_next = 6'(pend_addr);
        last_next    = 1'b0;
      end
      pend_valid_next = 1'b1;
      pend_owner_next = item_owner;
      pend_size_next  = item_size;
      pend_addr_next  = item_addr;
    end

    if (ctl.advance && cnt < n_units) begin
      cnt_next     = cnt + CW'(1);
      idx_d_next   = cnt[IW-1:0];
      d_valid_next = !hit;
    end

    if (ctl.finish) begin
      strobe_next  = 1'b1;
      owner_next   = 16'(who);
      size_next    = '0;
      address_next = '0;
      last_next    = 1'b1;
      unique case (op)
        OP_REQUEST: begin
          kind_next = K_REQFAIL;
          size_next = want;
        end
        OP_RELEASE: kind_next = K_RELFAIL;
        OP_FIND:    kind_next = K_FAULT;
        default: begin
          if (pend_valid) begin
            kind_next    = list_kind;
            owner_next   = 16'(pend_owner);
            size_next    = pend_size;
            address_next = 6'(pend_addr);
          end else begin
            kind_next  = K_NONE;
            owner_next = '0;
          end
        end
      endcase
    end

    if (ctl.load) begin
      op_next         = op_t'(command);
      who_next        = OWNER_BITS'(owner_id);
      want_next       = request_size;
      cnt_next        = '0;
      run_next        = '0;
      pend_valid_next = 1'b0;
      d_valid_next    = 1'b0;
    end
  end

  assign stat.hit  = hit;
  assign stat.done = (cnt == n_units) && !d_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      valid      <= '0;
      d_valid    <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
      cnt        <= '0;
      run        <= '0;
      op         <= OP_REQUEST;
    end else begin
      used       <= used_next;
      valid      <= valid_next;
      d_valid    <= d_valid_next;
      pend_valid <= pend_valid_next;
      strobe     <= strobe_next;
      cnt        <= cnt_next;
      run        <= run_next;
      op         <= op_next;
    end
  end

  always_ff @(posedge clk) begin
    who        <= who_next;
    want       <= want_next;
    idx_d      <= idx_d_next;
    pend_owner <= pend_owner_next;
    pend_size  <= pend_size_next;
    pend_addr  <= pend_addr_next;
    kind       <= kind_next;
    owner      <= owner_next;
    size       <= size_next;
    address    <= address_next;
    last       <= last_next;
  end

endmodule

// ----- test/first_fit_contiguous_allocator_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_contiguous_allocator: commands, config, result beats.
// Depends on ffca_pkg and the allocator RTL; a scoreboard class predicts every beat.
module first_fit_contiguous_allocator_test;
  import ffca_pkg::*;

  localparam int UNITS = 64;
  localparam int STALL_LIMIT = 3000;   // cycles with no beat of any kind

  typedef struct packed {
    kind_t       kind;
    logic [15:0] owner;
    logic [6:0]  size;
    logic [5:0]  address;
    logic        last;
  } beat_t;

  // Scoreboard: holds its own bitmap, table and register; predicts the beats
  // each accepted command causes and checks result beats in order.
  class alloc_scoreboard;
    bit          unit_busy[UNITS];
    bit          slot_valid[UNITS];
    logic [15:0] slot_owner[UNITS];
    bit   [6:0]  slot_len[UNITS];
    bit   [6:0]  unit_count;
    beat_t       pending[$];
    int          errors;
    int          beats_checked;
    int          cmds_noted;

    function new();
      for (int i = 0; i < UNITS; i++) begin
        unit_busy[i] = 0;
        slot_valid[i] = 0;
        slot_owner[i] = '0;
        slot_len[i] = '0;
      end
      unit_count = 7'd64;
      errors = 0;
      beats_checked = 0;
      cmds_noted = 0;
    endfunction

    function void set_units(bit [6:0] v);
      unit_count = v;
    endfunction

    function int live_units();
      if (unit_count < 1) return 1;
      if (unit_count > UNITS) return UNITS;
      return int'(unit_count);
    endfunction

    function int first_slot(int n, logic [15:0] who);
      for (int i = 0; i < n; i++)
        if (slot_valid[i] && slot_owner[i] == who) return i;
      return -1;
    endfunction

    function beat_t mk(kind_t k, logic [15:0] o, int sz, int ad, bit l);
      beat_t b;
      b.kind = k;
      b.owner = o;
      b.size = sz[6:0];
      b.address = ad[5:0];
      b.last = l;
      return b;
    endfunction

    function void note(logic [2:0] cmd, logic [15:0] who, logic [6:0] want);
      int n;
      int run;
      int st;
      int e;
      bit hit;
      beat_t lst[$];
      n = live_units();
      cmds_noted++;
      case (cmd)
        OP_REQUEST: begin
          hit = 0;
          run = 0;
          st = 0;
          if (want != 0) begin
            for (int i = 0; i < n; i++) begin
              if (unit_busy[i]) run = 0;
              else begin
                run++;
                if (!hit && run == int'(want)) begin
                  hit = 1;
                  st = i + 1 - int'(want);
                end
              end
            end
          end
          if (hit) begin
            for (int i = st; i < st + int'(want); i++) unit_busy[i] = 1;
            slot_valid[st] = 1;
            slot_owner[st] = who;
            slot_len[st] = want;
            pending.push_back(mk(K_ALLOC, who, want, st, 1));
          end else begin
            pending.push_back(mk(K_REQFAIL, who, want, 0, 1));
          end
        end
        OP_RELEASE: begin
          e = first_slot(n, who);
          if (e < 0) pending.push_back(mk(K_RELFAIL, who, 0, 0, 1));
          else begin
            for (int i = e; i < e + int'(slot_len[e]) && i < UNITS; i++) unit_busy[i] = 0;
            slot_valid[e] = 0;
            pending.push_back(mk(K_FREED, who, slot_len[e], e, 1));
          end
        end
        OP_FIND: begin
          e = first_slot(n, who);
          if (e < 0) pending.push_back(mk(K_FAULT, who, 0, 0, 1));
          else pending.push_back(mk(K_FOUND, who, slot_len[e], e, 1));
        end
        OP_LIST_FREE, OP_LIST_USED: begin
          run = 0;
          for (int i = 0; i < n; i++) begin
            if (cmd == OP_LIST_USED) begin
              if (slot_valid[i]) lst.push_back(mk(K_ASSIGNED, slot_owner[i], slot_len[i], i, 0));
            end else if (!unit_busy[i]) begin
              run++;
              if (i + 1 == n || unit_busy[i + 1]) begin
                lst.push_back(mk(K_HOLE, 16'h0, run, i + 1 - run, 0));
                run = 0;
              end
            end
          end
          if (lst.size() == 0) lst.push_back(mk(K_NONE, 16'h0, 0, 0, 1));
          else lst[lst.size() - 1].last = 1;
          foreach (lst[j]) pending.push_back(lst[j]);
        end
        default: ;  // unused codes: dropped, no beat
      endcase
    endfunction

    task report(string what);
      $display("MISMATCH %s", what);
      errors++;
    endtask

    task check(beat_t got);
      beat_t exp;
      beats_checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat kind=%0d owner=%h size=%0d addr=%0d last=%0b",
                         got.kind, got.owner, got.size, got.address, got.last));
        return;
      end
      exp = pending.pop_front();
      if (got.kind !== exp.kind || got.owner !== exp.owner || got.size !== exp.size ||
          got.address !== exp.address || got.last !== exp.last)
        report($sformatf("beat %0d got k=%0d o=%h s=%0d a=%0d l=%0b exp k=%0d o=%h s=%0d a=%0d l=%0b",
                         beats_checked, got.kind, got.owner, got.size, got.address, got.last,
                         exp.kind, exp.owner, exp.size, exp.address, exp.last));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  command;
  logic [15:0] owner_id;
  logic [6:0]  request_size;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  units_in_use;
  logic        strobe;
  logic [3:0]  kind;
  logic [15:0] owner;
  logic [6:0]  size;
  logic [5:0]  address;
  logic        last;

  alloc_scoreboard sb;
  int idle_pct;      // chance, in percent, that the sender idles before a beat
  int quiet_cycles;
  int settings_seen;

  first_fit_contiguous_allocator u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .owner_id(owner_id), .request_size(request_size),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .units_in_use(units_in_use),
    .strobe(strobe), .kind(kind), .owner(owner), .size(size),
    .address(address), .last(last)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Monitor: everything is sampled at the rising edge; drivers move on the falling edge.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (start && !busy) sb.note(command, owner_id, request_size);
      if (cfg_valid && cfg_ready) sb.set_units(units_in_use);
      if (strobe) sb.check({kind_t'(kind), owner, size, address, last});
      if ((start && !busy) || (cfg_valid && cfg_ready) || strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: the block or the run has hung.
  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results still due",
               quiet_cycles, sb.pending.size());
      $display("first_fit_contiguous_allocator_test NOT OK");
      $finish;
    end
  end

  // One command beat; optional idle gap first. Returns at the accepting edge.
  task automatic send_cmd(logic [2:0] c, logic [15:0] o, logic [6:0] s);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(negedge clk);
    end
    start <= 1'b1;
    command <= c;
    owner_id <= o;
    request_size <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and hold off until all results are in, then wait out the
  // length of a full scan more before returning.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (UNITS + 8) @(negedge clk);
  endtask

  task automatic write_units(logic [6:0] v);
    drain();
    cfg_valid <= 1'b1;
    units_in_use <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_seen++;
  endtask

  // Random traffic: mostly requests and releases from a small owner pool so
  // that finds and releases hit, with lists, stray codes and wide values mixed in.
  task automatic random_burst(int count);
    int r;
    logic [15:0] o;
    logic [6:0] s;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      o = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(7));
      if (r < 6) s = 7'($urandom_range(127));
      else if (r < 12) s = 7'($urandom_range(64, 20));
      else s = 7'($urandom_range(12, 1));
      if (i == count / 2) drain();   // let results run dry once mid-burst
      r = $urandom_range(99);
      if (r < 40) send_cmd(OP_REQUEST, o, s);
      else if (r < 65) send_cmd(OP_RELEASE, o, s);
      else if (r < 78) send_cmd(OP_FIND, o, s);
      else if (r < 86) send_cmd(OP_LIST_FREE, o, s);
      else if (r < 94) send_cmd(OP_LIST_USED, o, s);
      else send_cmd(3'($urandom_range(7, 5)), o, s);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    command = OP_REQUEST;
    owner_id = '0;
    request_size = '0;
    cfg_valid = 1'b0;
    units_in_use = 7'd64;
    idle_pct = 0;
    quiet_cycles = 0;
    settings_seen = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty lists, zero and oversize requests, whole-memory grab,
    // duplicate owners, release and find misses, stray codes.
    send_cmd(OP_LIST_FREE, 16'h0, 7'd0);
    send_cmd(OP_LIST_USED, 16'hFFFF, 7'd0);
    send_cmd(OP_REQUEST, 16'h1234, 7'd0);
    send_cmd(OP_REQUEST, 16'hFFFF, 7'd127);
    send_cmd(OP_REQUEST, 16'hFFFF, 7'd65);
    send_cmd(OP_REQUEST, 16'h0000, 7'd64);
    send_cmd(OP_LIST_FREE, 16'h0, 7'd0);
    send_cmd(OP_REQUEST, 16'h0001, 7'd1);
    send_cmd(OP_FIND, 16'h0000, 7'd0);
    send_cmd(OP_RELEASE, 16'h0000, 7'd0);
    send_cmd(OP_RELEASE, 16'h0000, 7'd0);
    send_cmd(OP_FIND, 16'h0000, 7'd0);
    send_cmd(OP_REQUEST, 16'hAAAA, 7'd3);
    send_cmd(OP_REQUEST, 16'h5555, 7'd5);
    send_cmd(OP_REQUEST, 16'hAAAA, 7'd2);
    send_cmd(OP_RELEASE, 16'h5555, 7'd0);
    send_cmd(OP_LIST_FREE, 16'h0, 7'd0);
    send_cmd(OP_LIST_USED, 16'h0, 7'd0);
    send_cmd(OP_FIND, 16'hAAAA, 7'd0);
    send_cmd(3'd5, 16'hFFFF, 7'd127);
    send_cmd(3'd6, 16'h0, 7'd1);
    send_cmd(3'd7, 16'h1, 7'd2);
    send_cmd(OP_REQUEST, 16'h0002, 7'd59);
    send_cmd(OP_LIST_USED, 16'h0, 7'd0);

    random_burst(40);
    idle_pct = 79;
    random_burst(30);
    write_units(7'd1);        // single unit
    random_burst(18);
    write_units(7'd0);        // below range, acts as one
    idle_pct = 18;
    random_burst(18);
    write_units(7'd127);      // above range, acts as full depth
    idle_pct = 0;
    random_burst(30);
    write_units(7'($urandom_range(40, 2)));
    idle_pct = 79;
    random_burst(30);
    write_units(7'd64);
    idle_pct = 18;
    random_burst(20);

    drain();
    repeat (2 * UNITS) @(posedge clk);
    $display("covered %0d commands, %0d result beats, %0d register settings",
             sb.cmds_noted, sb.beats_checked, settings_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("first_fit_contiguous_allocator_test OK");
    end else begin
      $display("%0d mismatches, %0d results never came", sb.errors, sb.pending.size());
      $display("first_fit_contiguous_allocator_test NOT OK");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hw/rtl/ffca_pkg.sv
hw/rtl/ffca_ram.sv
hw/rtl/ffca_ctrl.sv
hw/rtl/ffca_dp.sv
hw/rtl/first_fit_contiguous_allocator.sv
test/first_fit_contiguous_allocator_test.sv
